// ===== rtl/rbsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// widths, stage map and payload types of the ray/box slab test pipeline
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int ThrWidth   = 16;
  localparam int ThrReset   = 66;
  localparam int NumAxes    = 3;
  localparam int DivCount   = 2 * NumAxes;
  // quotient bits left after the overflow check
  localparam int QuotBits   = CoordWidth - 1;
  localparam int ShiftPre   = QuotBits - FracBits;

  // stage map
  localparam int IterStart    = 2;
  localparam int ResolveStage = IterStart + QuotBits;
  localparam int OrderStage   = ResolveStage + 1;
  localparam int AxisStage0   = OrderStage + 1;
  localparam int NumStages    = AxisStage0 + NumAxes;

  localparam logic [CoordWidth-1:0] TMin = {1'b1, {(CoordWidth-1){1'b0}}};
  localparam logic [CoordWidth-1:0] TMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] OneFx = CoordWidth'(1) << FracBits;

  typedef struct packed {
    logic                  sgn;
    logic                  ovf;
    logic [CoordWidth-1:0] dm;
    logic [CoordWidth-1:0] n;
    logic [CoordWidth-1:0] r;
    logic [QuotBits-1:0]   nlo;
    logic [QuotBits-1:0]   q;
  } div_t;

  typedef struct packed {
    logic par;
    logic pmiss;
  } axis_t;

  typedef struct packed {
    div_t  [DivCount-1:0]                 dv;
    axis_t [NumAxes-1:0]                  ax;
    logic  [DivCount-1:0][CoordWidth-1:0] t;
    logic  [CoordWidth-1:0]               tn;
    logic  [CoordWidth-1:0]               tf;
    logic                                 hit;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/ray_box_slab_intersect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// slab test of one ray against the unit box [0,1]^3, fully pipelined
// ----------------------------------------------------------------------------
// One ray transaction is taken per clock while the output side does not stall,
// and its result leaves after 38 register stages; the sustained rate is one ray
// per cycle when the output side never stalls. The depth is set by the six slab
// dividers, which run as restoring
// dividers with one quotient bit per stage (31 stages), framed by two setup
// stages in front and five stages behind them (sign and saturation, ordering
// of the slab pair, one stage per axis for the bound update). Each stage
// holds a valid bit and stalls only when it is full and the stage after it
// cannot take its contents, so bubbles close up under back-pressure. An axis
// whose direction magnitude does not exceed the threshold register is treated
// as parallel and only checks that the origin lies inside [0,1]. Quotients
// are truncated toward zero and saturate to the most negative / most positive
// value, which stand for minus / plus infinity. The threshold register is
// written through its own channel, which is always ready; write it only while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [rbsi_pkg::ThrWidth-1:0]         cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] origin_x_i,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] origin_y_i,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] origin_z_i,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] dir_x_i,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] dir_y_i,
  input  wire logic signed [rbsi_pkg::CoordWidth-1:0] dir_z_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       hit_o,
  output logic signed [rbsi_pkg::CoordWidth-1:0]     t_near_o,
  output logic signed [rbsi_pkg::CoordWidth-1:0]     t_far_o
);

  localparam int CW = rbsi_pkg::CoordWidth;
  localparam int QB = rbsi_pkg::QuotBits;
  localparam int SP = rbsi_pkg::ShiftPre;
  localparam int NS = rbsi_pkg::NumStages;

  // threshold register
  logic [rbsi_pkg::ThrWidth-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rbsi_pkg::ThrWidth'(rbsi_pkg::ThrReset);
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // pipeline storage
  logic           [NS-1:0] valid_q;
  logic           [NS:0]   rdy;
  rbsi_pkg::item_t         item_q [NS];
  rbsi_pkg::item_t         item_d [NS];

  assign rdy[NS]     = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NS-1];
  assign hit_o       = item_q[NS-1].hit;
  assign t_near_o    = $signed(item_q[NS-1].tn);
  assign t_far_o     = $signed(item_q[NS-1].tf);

  logic [rbsi_pkg::NumAxes-1:0][CW-1:0] org;
  logic [rbsi_pkg::NumAxes-1:0][CW-1:0] dir;

  assign org = {origin_z_i, origin_y_i, origin_x_i};
  assign dir = {dir_z_i, dir_y_i, dir_x_i};

  // stage 0: magnitudes, numerators, parallel test
  always_comb begin
    logic signed [CW-1:0] o;
    logic signed [CW-1:0] d;
    logic                 dneg;
    logic [CW-1:0]        dm;
    item_d[0] = '0;
    for (int a = 0; a < rbsi_pkg::NumAxes; a++) begin
      o    = $signed(org[a]);
      d    = $signed(dir[a]);
      dneg = d[CW-1];
      dm   = dneg ? (CW'(0) - dir[a]) : dir[a];
      item_d[0].ax[a].par   = (dm <= CW'(thr_q));
      item_d[0].ax[a].pmiss = (o > $signed(rbsi_pkg::OneFx)) || o[CW-1];
      // far face, 1 - o
      item_d[0].dv[2*a].dm  = dm;
      item_d[0].dv[2*a].sgn = (o > $signed(rbsi_pkg::OneFx)) ^ dneg;
      item_d[0].dv[2*a].n   = (o > $signed(rbsi_pkg::OneFx)) ?
                              (org[a] - rbsi_pkg::OneFx) : (rbsi_pkg::OneFx - org[a]);
      // near face, 0 - o
      item_d[0].dv[2*a+1].dm  = dm;
      item_d[0].dv[2*a+1].sgn = !o[CW-1] ^ dneg;
      item_d[0].dv[2*a+1].n   = o[CW-1] ? (CW'(0) - org[a]) : org[a];
    end
    item_d[0].tn  = rbsi_pkg::TMin;
    item_d[0].tf  = rbsi_pkg::TMax;
    item_d[0].hit = 1'b1;
  end

  // stage 1: overflow check and first partial remainder
  always_comb begin
    item_d[1] = item_q[0];
    for (int i = 0; i < rbsi_pkg::DivCount; i++) begin
      item_d[1].dv[i].ovf = {{SP{1'b0}}, item_q[0].dv[i].n} >=
                            {item_q[0].dv[i].dm, {SP{1'b0}}};
      item_d[1].dv[i].r   = item_q[0].dv[i].n >> SP;
      item_d[1].dv[i].nlo = {item_q[0].dv[i].n[SP-1:0], {rbsi_pkg::FracBits{1'b0}}};
      item_d[1].dv[i].q   = '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign rdy[k] = !valid_q[k] | rdy[k+1];

    if (k >= rbsi_pkg::IterStart && k < rbsi_pkg::ResolveStage) begin : g_iter
      // one restoring step per divider
      always_comb begin
        logic [CW:0] rr;
        item_d[k] = item_q[k-1];
        for (int i = 0; i < rbsi_pkg::DivCount; i++) begin
          rr = {item_q[k-1].dv[i].r, item_q[k-1].dv[i].nlo[QB-1]};
          item_d[k].dv[i].nlo = {item_q[k-1].dv[i].nlo[QB-2:0], 1'b0};
          if (rr >= {1'b0, item_q[k-1].dv[i].dm}) begin
            item_d[k].dv[i].r = CW'(rr - {1'b0, item_q[k-1].dv[i].dm});
            item_d[k].dv[i].q = {item_q[k-1].dv[i].q[QB-2:0], 1'b1};
          end else begin
            item_d[k].dv[i].r = rr[CW-1:0];
            item_d[k].dv[i].q = {item_q[k-1].dv[i].q[QB-2:0], 1'b0};
          end
        end
      end
    end else if (k == rbsi_pkg::ResolveStage) begin : g_resolve
      // sign and saturation
      always_comb begin
        logic [CW-1:0] mag;
        item_d[k] = item_q[k-1];
        for (int i = 0; i < rbsi_pkg::DivCount; i++) begin
          mag = {1'b0, item_q[k-1].dv[i].q};
          if (item_q[k-1].dv[i].ovf) begin
            item_d[k].t[i] = item_q[k-1].dv[i].sgn ? rbsi_pkg::TMin : rbsi_pkg::TMax;
          end else begin
            item_d[k].t[i] = item_q[k-1].dv[i].sgn ? (CW'(0) - mag) : mag;
          end
        end
      end
    end else if (k == rbsi_pkg::OrderStage) begin : g_order
      // lower slab distance first
      always_comb begin
        item_d[k] = item_q[k-1];
        for (int a = 0; a < rbsi_pkg::NumAxes; a++) begin
          if ($signed(item_q[k-1].t[2*a]) > $signed(item_q[k-1].t[2*a+1])) begin
            item_d[k].t[2*a]   = item_q[k-1].t[2*a+1];
            item_d[k].t[2*a+1] = item_q[k-1].t[2*a];
          end
        end
      end
    end else if (k >= rbsi_pkg::AxisStage0) begin : g_axis
      localparam int A = k - rbsi_pkg::AxisStage0;
      // narrow the bounds on one axis, stop on the first miss
      always_comb begin
        logic [CW-1:0] ntn;
        logic [CW-1:0] ntf;
        item_d[k] = item_q[k-1];
        ntn = ($signed(item_q[k-1].t[2*A]) > $signed(item_q[k-1].tn)) ?
              item_q[k-1].t[2*A] : item_q[k-1].tn;
        ntf = ($signed(item_q[k-1].t[2*A+1]) < $signed(item_q[k-1].tf)) ?
              item_q[k-1].t[2*A+1] : item_q[k-1].tf;
        if (item_q[k-1].hit) begin
          if (!item_q[k-1].ax[A].par) begin
            item_d[k].tn = ntn;
            item_d[k].tf = ntf;
            if (($signed(ntn) > $signed(ntf)) || ntf[CW-1]) begin
              item_d[k].hit = 1'b0;
            end
          end else if (item_q[k-1].ax[A].pmiss) begin
            item_d[k].hit = 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        item_q[k] <= item_d[k];
      end
    end
  end

  // remainder stays below the divisor at the end of the divider chain
  logic rem_ok;

  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < rbsi_pkg::DivCount; i++) begin
      if (!item_q[rbsi_pkg::ResolveStage-1].dv[i].ovf &&
          item_q[rbsi_pkg::ResolveStage-1].dv[i].r >=
          item_q[rbsi_pkg::ResolveStage-1].dv[i].dm) begin
        rem_ok = 1'b0;
      end
    end
  end

  a_hit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (t_near_o <= t_far_o) && !t_far_o[CW-1])
    else $error("hit reported with crossed or negative bounds");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[rbsi_pkg::ResolveStage-1] |-> rem_ok)
    else $error("divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NS-2] && !rdy[NS-1] |=> valid_q[NS-2])
    else $error("stage lost under stall");

endmodule
`default_nettype wire
